// File: rtl/uvsg_pkg.sv
`timescale 1ns / 1ps
package uvsg_pkg;

  localparam int MAX_RINGS   = 64;
  localparam int MAX_SECTORS = 64;
  localparam int TRIG_FB     = 15;

  localparam int IDX_W  = 6;
  localparam int CNT_W  = 7;
  localparam int RAD_W  = 24;
  localparam int POS_W  = 25;
  localparam int TEX_W  = 17;
  localparam int PH_W   = 17;
  localparam int TRIG_W = TRIG_FB + 2;
  localparam int MAG_W  = TRIG_W - 1;
  localparam int DIVD_W = CNT_W + 16;

  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = (TEX_W + DIV_BITS - 1) / DIV_BITS;
  localparam int TRIG_LAT   = 8;
  localparam int LINE_LEN   = DIV_STAGES + TRIG_LAT + 2;
  localparam int UV_LEN     = TRIG_LAT + 2;

  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_RADIUS  = 2'd0;
  localparam logic [1:0] REG_RINGS   = 2'd1;
  localparam logic [1:0] REG_SECTORS = 2'd2;

  localparam logic [RAD_W-1:0] RADIUS_RST  = RAD_W'(128000);
  localparam logic [CNT_W-1:0] RINGS_RST   = CNT_W'(16);
  localparam logic [CNT_W-1:0] SECTORS_RST = CNT_W'(32);

  localparam logic [PH_W-1:0] QUARTER = PH_W'(32768);

  localparam logic [30:0] C1 = 31'd1686629713;
  localparam logic [30:0] C3 = 31'd693598668;
  localparam logic [30:0] C5 = 31'd85569306;
  localparam logic [30:0] C7 = 31'd5026995;
  localparam logic [30:0] C9 = 31'd172272;

  typedef struct packed {
    logic valid;
    logic bad;
    logic last;
  } vflag_t;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_z;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic             bad;
    logic             last;
  } vtx_t;

  function automatic logic vtx_di(input logic [2:0] k);
    vtx_di = (k == 3'd1) || (k == 3'd4) || (k == 3'd5);
  endfunction

  function automatic logic vtx_dj(input logic [2:0] k);
    vtx_dj = (k == 3'd2) || (k == 3'd3) || (k == 3'd5);
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [TRIG_W-1:0] a);
    mag_of = a[TRIG_W-1] ? MAG_W'(-a) : MAG_W'(a);
  endfunction

  function automatic logic signed [TRIG_W-1:0] mr_trig(input logic signed [TRIG_W-1:0] a,
                                                       input logic signed [TRIG_W-1:0] b);
    logic [2*MAG_W-1:0] prod;
    logic [2*MAG_W:0]   rnd;
    logic [MAG_W-1:0]   m;
    prod = mag_of(a) * mag_of(b);
    rnd  = (2*MAG_W+1)'(prod) + (2*MAG_W+1)'(1 << (TRIG_FB - 1));
    m    = MAG_W'(rnd >> TRIG_FB);
    mr_trig = (a[TRIG_W-1] != b[TRIG_W-1]) ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic logic [POS_W-1:0] mr_rad(input logic signed [TRIG_W-1:0] a,
                                              input logic [RAD_W-1:0] r);
    logic [MAG_W+RAD_W-1:0] prod;
    logic [MAG_W+RAD_W:0]   rnd;
    logic [POS_W-1:0]       m;
    prod = mag_of(a) * r;
    rnd  = (MAG_W+RAD_W+1)'(prod) + (MAG_W+RAD_W+1)'(1 << (TRIG_FB - 1));
    m    = POS_W'(rnd >> TRIG_FB);
    mr_rad = a[TRIG_W-1] ? -m : m;
  endfunction

endpackage

// File: rtl/uvsg_in_if.sv
`timescale 1ns / 1ps
interface uvsg_in_if;
  import uvsg_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] ring_index;
  logic [IDX_W-1:0] sector_index;

  modport source (output valid, ring_index, sector_index, input ready);
  modport sink (input valid, ring_index, sector_index, output ready);
endinterface

// File: rtl/uvsg_out_if.sv
`timescale 1ns / 1ps
interface uvsg_out_if;
  import uvsg_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [TEX_W-1:0]        tex_u;
  logic [TEX_W-1:0]        tex_v;
  logic                    bad_cell;
  logic                    last_vertex;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, bad_cell, last_vertex,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, bad_cell, last_vertex,
                output ready);
endinterface

// File: rtl/uvsg_div.sv
`timescale 1ns / 1ps
module uvsg_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [uvsg_pkg::DIVD_W-1:0]   dividend,
  input  logic [uvsg_pkg::CNT_W-1:0]    divisor,
  output logic [uvsg_pkg::TEX_W-1:0]    quotient
);
  import uvsg_pkg::*;

  logic [CNT_W-1:0]  rem_r [DIV_STAGES];
  logic [TEX_W-1:0]  q_r   [DIV_STAGES];
  logic [DIVD_W-1:0] d_r   [DIV_STAGES];
  logic [CNT_W-1:0]  n_r   [DIV_STAGES];
  logic [CNT_W-1:0]  rem_nxt [DIV_STAGES];
  logic [TEX_W-1:0]  q_nxt   [DIV_STAGES];

  always_comb begin
    logic [CNT_W-1:0]  rem;
    logic [TEX_W-1:0]  q;
    logic [DIVD_W-1:0] d;
    logic [CNT_W-1:0]  n;
    logic [CNT_W:0]    trial;
    int                k;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        rem = CNT_W'(dividend >> TEX_W);
        q   = '0;
        d   = dividend;
        n   = divisor;
      end else begin
        rem = rem_r[(s == 0) ? 0 : s - 1];
        q   = q_r[(s == 0) ? 0 : s - 1];
        d   = d_r[(s == 0) ? 0 : s - 1];
        n   = n_r[(s == 0) ? 0 : s - 1];
      end
      for (int t = 0; t < DIV_BITS; t++) begin
        k = TEX_W - 1 - s * DIV_BITS - t;
        if (k >= 0) begin
          trial = {rem, d[5'(k)]};
          if (trial >= {1'b0, n}) begin
            rem = CNT_W'(trial - {1'b0, n});
            q[5'(k)] = 1'b1;
          end else begin
            rem = trial[CNT_W-1:0];
          end
        end
      end
      rem_nxt[s] = rem;
      q_nxt[s]   = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= dividend;
      n_r[0] <= divisor;
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
      end
      for (int s = 1; s < DIV_STAGES; s++) begin
        d_r[s] <= d_r[s-1];
        n_r[s] <= n_r[s-1];
      end
    end
  end

  assign quotient = q_r[DIV_STAGES-1];
endmodule

// File: rtl/uvsg_trig.sv
`timescale 1ns / 1ps
module uvsg_trig (
  input  logic                               clk,
  input  logic                               en,
  input  logic [uvsg_pkg::PH_W-1:0]          phase,
  output logic signed [uvsg_pkg::TRIG_W-1:0] sine
);
  import uvsg_pkg::*;

  localparam int SH = 30 - TRIG_FB;
  localparam logic [30:0] COEF [4] = '{C7, C5, C3, C1};

  logic [15:0]  x_r    [6];
  logic [1:0]   quad_r [7];
  logic [30:0]  x2_r   [4];
  logic [30:0]  p_r    [4];
  logic [31:0]  s_r;
  logic signed [TRIG_W-1:0] sine_r;

  logic [14:0]  rpart;
  logic [15:0]  x_nxt;
  logic [30:0]  p_nxt [4];
  logic [46:0]  sprod;
  logic [32:0]  srnd;
  logic [TRIG_W-2:0] m;

  always_comb begin
    rpart = phase[14:0];
    x_nxt = phase[15] ? (16'd32768 - {1'b0, rpart}) : {1'b0, rpart};
  end

  always_comb begin
    logic [61:0] prod;
    logic [30:0] opnd;
    for (int t = 0; t < 4; t++) begin
      opnd     = (t == 0) ? C9 : p_r[(t == 0) ? 0 : t - 1];
      prod     = 62'(x2_r[t]) * 62'(opnd);
      p_nxt[t] = COEF[t] - prod[60:30];
    end
  end

  always_comb begin
    sprod = 47'(x_r[5]) * 47'(p_r[3]);
    srnd  = 33'(s_r) + 33'(1 << (SH - 1));
    if ((srnd >> SH) > 33'(1 << TRIG_FB)) begin
      m = (TRIG_W-1)'(1 << TRIG_FB);
    end else begin
      m = (TRIG_W-1)'(srnd >> SH);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x_nxt;
      quad_r[0] <= phase[16:15];
      for (int i = 1; i < 6; i++) x_r[i] <= x_r[i-1];
      for (int i = 1; i < 7; i++) quad_r[i] <= quad_r[i-1];
      x2_r[0] <= 31'(x_r[0] * x_r[0]);
      for (int i = 1; i < 4; i++) x2_r[i] <= x2_r[i-1];
      for (int i = 0; i < 4; i++) p_r[i] <= p_nxt[i];
      s_r    <= sprod[46:15];
      sine_r <= quad_r[6][1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    end
  end

  assign sine = sine_r;
endmodule

// File: rtl/uv_sphere_vertex_generator_top.sv
`timescale 1ns / 1ps
// UV sphere vertex generator.
// in_chan takes one mesh cell (ring_index, sector_index) per transfer; out_chan
// returns the six vertices of the cell's two triangles, one vertex per transfer,
// with last_vertex on the sixth. A cell outside ring_count/sector_count gives a
// single transfer with bad_cell and last_vertex set and all other fields zero.
// Registers on the APB port: 0x0 sphere_radius, 0x4 ring_count, 0x8 sector_count;
// write them only while no cell is in flight.
// Throughput: one vertex per cycle while the output queue has room, and one bad
// cell per cycle; a good cell keeps in_chan.ready low until its sixth vertex issues;
// the vertex sequencer that walks the six corners sets this rate.
// Pipeline: sequencer, 5-stage divider, 8-stage sine pipeline, 2 scaling stages
// and output queue.
// Reset: the registers return to radius 500.0, 16 rings, 32 sectors, and the
// pipeline empties; no clearing pass follows.
// Stall: a 2-entry output queue absorbs the result; when it is full the whole
// pipeline holds and in_chan.ready drops once the sequencer holds a cell.
module uv_sphere_vertex_generator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  uvsg_in_if.sink                       in_chan,
  uvsg_out_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uvsg_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import uvsg_pkg::*;

  logic [RAD_W-1:0] radius_r;
  logic [CNT_W-1:0] rings_r;
  logic [CNT_W-1:0] sectors_r;
  logic             cfg_wr;

  logic             cell_valid_r;
  logic [IDX_W-1:0] cell_i_r;
  logic [IDX_W-1:0] cell_j_r;
  logic             cell_bad_r;
  logic [2:0]       k_r;
  logic             issue;
  logic             last_issue;
  logic             accept;
  logic             bad_nxt;

  vflag_t           s0_r;
  logic [CNT_W-1:0] a_r;
  logic [CNT_W-1:0] b_r;
  vflag_t           line_r [LINE_LEN];
  logic [TEX_W-1:0] u_line_r [UV_LEN];
  logic [TEX_W-1:0] v_line_r [UV_LEN];

  logic             en;
  logic [DIVD_W-1:0] dv_u;
  logic [DIVD_W-1:0] dv_v;
  logic [TEX_W-1:0] q_u;
  logic [TEX_W-1:0] q_v;
  logic [PH_W-1:0]  ph_p;
  logic [PH_W-1:0]  ph_a;
  logic signed [TRIG_W-1:0] sin_p;
  logic signed [TRIG_W-1:0] cos_p;
  logic signed [TRIG_W-1:0] sin_a;
  logic signed [TRIG_W-1:0] cos_a;

  logic signed [TRIG_W-1:0] sx_r;
  logic signed [TRIG_W-1:0] sz_r;
  logic [POS_W-1:0] y1_r;
  logic [POS_W-1:0] x2_r;
  logic [POS_W-1:0] y2_r;
  logic [POS_W-1:0] z2_r;

  vtx_t             fifo_r [2];
  logic             wp_r;
  logic             rp_r;
  logic [1:0]       cnt_r;
  logic             push;
  logic             pop;
  vtx_t             vin;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= RADIUS_RST;
      rings_r   <= RINGS_RST;
      sectors_r <= SECTORS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_RADIUS:  radius_r  <= pwdata[RAD_W-1:0];
        REG_RINGS:   rings_r   <= pwdata[CNT_W-1:0];
        REG_SECTORS: sectors_r <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RADIUS:  prdata = 32'(radius_r);
      REG_RINGS:   prdata = 32'(rings_r);
      REG_SECTORS: prdata = 32'(sectors_r);
      default:     prdata = '0;
    endcase
  end

  assign en         = (cnt_r != 2'd2);
  assign issue      = en && cell_valid_r;
  assign last_issue = cell_bad_r || (k_r == 3'd5);
  assign in_chan.ready = !cell_valid_r || (issue && last_issue);
  assign accept     = in_chan.valid && in_chan.ready;
  assign bad_nxt    = ({1'b0, in_chan.ring_index} >= rings_r)
                   || ({1'b0, in_chan.sector_index} >= sectors_r)
                   || (32'(in_chan.ring_index) >= 32'(MAX_RINGS))
                   || (32'(in_chan.sector_index) >= 32'(MAX_SECTORS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_valid_r <= 1'b0;
      k_r          <= '0;
    end else begin
      if (issue) begin
        k_r <= last_issue ? 3'd0 : k_r + 3'd1;
      end
      if (accept) begin
        cell_valid_r <= 1'b1;
      end else if (issue && last_issue) begin
        cell_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cell_i_r   <= in_chan.ring_index;
      cell_j_r   <= in_chan.sector_index;
      cell_bad_r <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r <= '0;
      for (int i = 0; i < LINE_LEN; i++) line_r[i] <= '0;
    end else if (en) begin
      s0_r <= '{valid: issue, bad: cell_bad_r, last: last_issue};
      line_r[0] <= s0_r;
      for (int i = 1; i < LINE_LEN; i++) line_r[i] <= line_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= {1'b0, cell_i_r} + CNT_W'(vtx_di(k_r));
      b_r <= {1'b0, cell_j_r} + CNT_W'(vtx_dj(k_r));
      u_line_r[0] <= q_u;
      v_line_r[0] <= q_v;
      for (int i = 1; i < UV_LEN; i++) begin
        u_line_r[i] <= u_line_r[i-1];
        v_line_r[i] <= v_line_r[i-1];
      end
    end
  end

  assign dv_u = {b_r, 16'd0} + DIVD_W'(sectors_r >> 1);
  assign dv_v = {a_r, 16'd0} + DIVD_W'(rings_r >> 1);

  uvsg_div u_div_u (.clk(clk), .en(en), .dividend(dv_u), .divisor(sectors_r),
                    .quotient(q_u));
  uvsg_div u_div_v (.clk(clk), .en(en), .dividend(dv_v), .divisor(rings_r),
                    .quotient(q_v));

  assign ph_p = q_v;
  assign ph_a = {q_u[PH_W-2:0], 1'b0};

  uvsg_trig u_sin_p (.clk(clk), .en(en), .phase(ph_p), .sine(sin_p));
  uvsg_trig u_cos_p (.clk(clk), .en(en), .phase(ph_p + QUARTER), .sine(cos_p));
  uvsg_trig u_sin_a (.clk(clk), .en(en), .phase(ph_a), .sine(sin_a));
  uvsg_trig u_cos_a (.clk(clk), .en(en), .phase(ph_a + QUARTER), .sine(cos_a));

  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= mr_trig(sin_p, cos_a);
      sz_r <= mr_trig(sin_p, sin_a);
      y1_r <= mr_rad(cos_p, radius_r);
      x2_r <= mr_rad(sx_r, radius_r);
      z2_r <= mr_rad(sz_r, radius_r);
      y2_r <= y1_r;
    end
  end

  always_comb begin
    vin.bad  = line_r[LINE_LEN-1].bad;
    vin.last = line_r[LINE_LEN-1].last;
    if (line_r[LINE_LEN-1].bad) begin
      vin.pos_x = '0;
      vin.pos_y = '0;
      vin.pos_z = '0;
      vin.tex_u = '0;
      vin.tex_v = '0;
    end else begin
      vin.pos_x = x2_r;
      vin.pos_y = y2_r;
      vin.pos_z = z2_r;
      vin.tex_u = u_line_r[UV_LEN-1];
      vin.tex_v = v_line_r[UV_LEN-1];
    end
  end

  assign push = en && line_r[LINE_LEN-1].valid;
  assign pop  = (cnt_r != 2'd0) && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= vin;
  end

  assign out_chan.valid       = (cnt_r != 2'd0);
  assign out_chan.pos_x       = fifo_r[rp_r].pos_x;
  assign out_chan.pos_y       = fifo_r[rp_r].pos_y;
  assign out_chan.pos_z       = fifo_r[rp_r].pos_z;
  assign out_chan.tex_u       = fifo_r[rp_r].tex_u;
  assign out_chan.tex_v       = fifo_r[rp_r].tex_v;
  assign out_chan.bad_cell    = fifo_r[rp_r].bad;
  assign out_chan.last_vertex = fifo_r[rp_r].last;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("output queue overflow");
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.bad_cell |-> out_chan.last_vertex && out_chan.pos_x == '0
      && out_chan.pos_y == '0 && out_chan.pos_z == '0)
    else $error("bad cell result not clean");
  a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> cell_valid_r && k_r == 3'd0)
    else $error("accepted cell not loaded");
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n) k_r <= 3'd5)
    else $error("corner counter out of range");
`endif
endmodule

// File: test/uv_sphere_vertex_generator_top_test.sv
`timescale 1ns / 1ps
module uv_sphere_vertex_generator_top_test;
  import uvsg_pkg::*;

  typedef struct {
    int unsigned ring;
    int unsigned sector;
    bit          reject;
  } cell_row_t;

  typedef struct {
    int unsigned radius;
    int unsigned rings;
    int unsigned sectors;
    int unsigned idle_pct;
    int unsigned stall_pct;
    int unsigned cells;
  } mesh_phase_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  uvsg_in_if  in_bus ();
  uvsg_out_if out_bus ();

  uv_sphere_vertex_generator_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_bus),
    .out_chan(out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  vtx_t pending_vertices[$];
  int unsigned failures = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  longint unsigned radius_q = 128000;
  longint unsigned rings_q = 16;
  longint unsigned sectors_q = 32;

  cell_row_t cell_table[] = '{
    '{0, 0, 0}, '{15, 31, 0}, '{15, 0, 0}, '{0, 31, 0}, '{8, 16, 0}, '{7, 8, 0},
    '{4, 24, 0}, '{1, 1, 0}, '{12, 5, 0}, '{3, 30, 0}, '{16, 0, 1}, '{0, 32, 1},
    '{63, 63, 1}, '{63, 0, 1}, '{0, 63, 1}, '{16, 32, 1}, '{9, 17, 0}, '{14, 29, 0}
  };

  mesh_phase_t phases[] = '{
    '{24'hFFFFFF, 64, 64, 0, 0, 40},
    '{0, 1, 1, 65, 0, 25},
    '{77777, 127, 3, 0, 65, 40},
    '{12345, 64, 64, 15, 15, 40},
    '{128000, 0, 64, 0, 0, 12},
    '{1, 37, 0, 65, 65, 12},
    '{128000, 16, 32, 0, 0, 45}
  };

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic void enqueue_vertex(vtx_t vx);
    pending_vertices.insert(pending_vertices.size(), vx);
  endfunction

  function automatic longint sine_q15(longint unsigned phase);
    longint unsigned ph, quad, r, x, x30, x2, p, s, m;
    ph = phase & 64'h1FFFF;
    quad = ph >> 15;
    r = ph & 64'h7FFF;
    x = quad[0] ? 64'd32768 - r : r;
    x30 = x << 15;
    x2 = (x30 * x30) >> 30;
    p = C9;
    p = C7 - ((x2 * p) >> 30);
    p = C5 - ((x2 * p) >> 30);
    p = C3 - ((x2 * p) >> 30);
    p = C1 - ((x2 * p) >> 30);
    s = (x30 * p) >> 30;
    m = (s + 64'd16384) >> 15;
    if (m > 64'd32768) m = 64'd32768;
    return quad[1] ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint scale_round(longint a, longint b);
    longint unsigned ma, mb, r;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    r = (ma * mb + 64'd16384) >> 15;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic vtx_t sphere_vertex(longint unsigned a, longint unsigned b, bit last);
    vtx_t vx;
    longint unsigned u, v;
    longint sp, cp, sa, ca, x, y, z;
    u = (b * 65536 + sectors_q / 2) / sectors_q;
    v = (a * 65536 + rings_q / 2) / rings_q;
    sp = sine_q15(v);
    cp = sine_q15(v + 32768);
    sa = sine_q15(u * 2);
    ca = sine_q15(u * 2 + 32768);
    x = scale_round(scale_round(sp, ca), longint'(radius_q));
    y = scale_round(cp, longint'(radius_q));
    z = scale_round(scale_round(sp, sa), longint'(radius_q));
    vx.pos_x = x[POS_W-1:0];
    vx.pos_y = y[POS_W-1:0];
    vx.pos_z = z[POS_W-1:0];
    vx.tex_u = u[TEX_W-1:0];
    vx.tex_v = v[TEX_W-1:0];
    vx.bad = 1'b0;
    vx.last = last;
    return vx;
  endfunction

  task automatic queue_cell_vertices(int unsigned i, int unsigned j);
    if (i >= rings_q || j >= sectors_q) begin
      enqueue_vertex('{default: '0, bad: 1'b1, last: 1'b1});
    end else begin
      for (int k = 0; k < 6; k++) begin
        enqueue_vertex(sphere_vertex(i + vtx_di(3'(k)), j + vtx_dj(3'(k)), k == 5));
      end
    end
  endtask

  task automatic send_cell(int unsigned i, int unsigned j);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.ring_index <= IDX_W'(i);
    in_bus.sector_index <= IDX_W'(j);
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain_vertices();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_vertices.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  always @(posedge clk) begin
    vtx_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_vertices.size() == 0) begin
        failures++;
        $display("%0t: unexpected vertex x=%0d bad=%0b last=%0b", $time,
                 out_bus.pos_x, out_bus.bad_cell, out_bus.last_vertex);
      end else begin
        want = pending_vertices.pop_front();
        if (out_bus.pos_x !== want.pos_x || out_bus.pos_y !== want.pos_y ||
            out_bus.pos_z !== want.pos_z || out_bus.tex_u !== want.tex_u ||
            out_bus.tex_v !== want.tex_v || out_bus.bad_cell !== want.bad ||
            out_bus.last_vertex !== want.last) begin
          failures++;
          $display("%0t: expected x=%0h y=%0h z=%0h u=%0h v=%0h bad=%0b last=%0b", $time,
                   want.pos_x, want.pos_y, want.pos_z, want.tex_u, want.tex_v,
                   want.bad, want.last);
          $display("%0t: actual   x=%0h y=%0h z=%0h u=%0h v=%0h bad=%0b last=%0b", $time,
                   out_bus.pos_x, out_bus.pos_y, out_bus.pos_z, out_bus.tex_u,
                   out_bus.tex_v, out_bus.bad_cell, out_bus.last_vertex);
        end
      end
    end
    out_bus.ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned ri, si, hi_r, hi_s;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_bus.valid = 1'b0;
    in_bus.ring_index = '0;
    in_bus.sector_index = '0;
    out_bus.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (cell_table[n]) begin
      send_cell(cell_table[n].ring, cell_table[n].sector);
      if (cell_table[n].reject)
        enqueue_vertex('{default: '0, bad: 1'b1, last: 1'b1});
      else
        queue_cell_vertices(cell_table[n].ring, cell_table[n].sector);
    end
    drain_vertices();

    foreach (phases[p]) begin
      write_reg(REG_RADIUS, phases[p].radius);
      write_reg(REG_RINGS, phases[p].rings);
      write_reg(REG_SECTORS, phases[p].sectors);
      radius_q = phases[p].radius;
      rings_q = phases[p].rings;
      sectors_q = phases[p].sectors;
      idle_pct = phases[p].idle_pct;
      stall_pct = phases[p].stall_pct;
      hi_r = (rings_q > 64) ? 64 : rings_q;
      hi_s = (sectors_q > 64) ? 64 : sectors_q;
      for (int n = 0; n < phases[p].cells; n++) begin
        if ($urandom_range(99) < 80 && hi_r > 0 && hi_s > 0) begin
          ri = $urandom_range(hi_r - 1);
          si = $urandom_range(hi_s - 1);
        end else begin
          ri = $urandom_range(63);
          si = $urandom_range(63);
        end
        send_cell(ri, si);
        queue_cell_vertices(ri, si);
      end
      drain_vertices();
    end

    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
